@@ rtl/assert_macros.svh @@
// assertion macros used by civil_date_to_epoch_ms
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, cond, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, cond, expr)
`endif
`endif

@@ rtl/cdte_pkg.sv @@
// widths, constants and calendar tables for the date to epoch converter
package cdte_pkg;

   localparam int YEAR_W  = 16;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;
   localparam int NANO_W  = 30;
   localparam int TS_W    = 51;

   localparam int U_W     = 17;
   localparam int Q_W     = 10;
   localparam int DAYS_W  = 26;
   localparam int TOD_W   = 17;
   localparam int MSN_W   = 10;
   localparam int SECS_W  = 43;
   localparam int MS_W    = 52;

   // year offset that makes (year - 1) a nonnegative multiple-of-400 shift
   localparam logic [U_W-1:0] YEAR_OFS  = 17'd32799;
   localparam logic [17:0]    RECIP_100 = 18'd167773;   // ceil(2^24 / 100)
   localparam logic [30:0]    RECIP_1M  = 31'd1125899907; // ceil(2^50 / 1e6)
   localparam logic [13:0]    LEAP_BIAS = 14'd8431;
   localparam logic [U_W-1:0] EPOCH_YEAR = 17'd1970;
   localparam logic [29:0]    NANO_MAX  = 30'd999999999;
   localparam int DAYS_LIMIT = 13000000;

   function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
      logic [8:0] d;
      case (m)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
      logic [DAY_W-1:0] d;
      case (m)
         4'd2:    d = leap ? 5'd29 : 5'd28;
         4'd4:    d = 5'd30;
         4'd6:    d = 5'd30;
         4'd9:    d = 5'd30;
         4'd11:   d = 5'd30;
         default: d = 5'd31;
      endcase
      return d;
   endfunction

endpackage

@@ rtl/cdte_if.sv @@
// request and response channel interfaces
interface cdte_req_if;
   import cdte_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [YEAR_W-1:0]  year;
   logic [MONTH_W-1:0]        month;
   logic [DAY_W-1:0]          day_of_month;
   logic [HOUR_W-1:0]         hour;
   logic [MIN_W-1:0]          minute;
   logic [SEC_W-1:0]          second;
   logic [NANO_W-1:0]         nanosecond;

   modport source (output valid, year, month, day_of_month, hour, minute, second,
                   nanosecond, input ready);
   modport sink   (input valid, year, month, day_of_month, hour, minute, second,
                   nanosecond, output ready);
endinterface

interface cdte_rsp_if;
   import cdte_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [TS_W-1:0]  timestamp_ms;
   logic                    invalid;

   modport source (output valid, timestamp_ms, invalid, input ready);
   modport sink   (input valid, timestamp_ms, invalid, output ready);
endinterface

@@ rtl/civil_date_to_epoch_ms.sv @@
// civil date and time to signed unix milliseconds, five stage pipeline
// Converts one proleptic Gregorian date and time per cycle into signed
// milliseconds since 1970-01-01 00:00:00, with invalid set and a zero
// timestamp when any field is out of range. A new request is taken every
// cycle unless back pressure stalls the pipeline. The stages are:
// year/nanosecond reciprocal multiplies, leap rule and day count, day to
// seconds multiply, time of day add, and seconds to milliseconds. Each stage
// holds while the stage after it is full and stalled, so back pressure on
// the response ripples back to req ready without losing or repeating data.
`include "assert_macros.svh"

module civil_date_to_epoch_ms (
   input logic    clock,
   input logic    reset,
   cdte_req_if.sink   req_if,
   cdte_rsp_if.source rsp_if
);
   import cdte_pkg::*;

   localparam logic signed [17:0] SEC_PER_DAY = 18'sd86400;
   localparam logic signed [11:0] MS_PER_SEC  = 12'sd1000;

   logic a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff, e_vld_ff;
   logic a_en, b_en, c_en, d_en, e_en;
   logic req_fire;

   assign e_en = !e_vld_ff || rsp_if.ready;
   assign d_en = !d_vld_ff || e_en;
   assign c_en = !c_vld_ff || d_en;
   assign b_en = !b_vld_ff || c_en;
   assign a_en = !a_vld_ff || b_en;
   assign req_if.ready = a_en;
   assign req_fire = req_if.valid && a_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
      end else begin
         if (a_en) a_vld_ff <= req_if.valid;
         if (b_en) b_vld_ff <= a_vld_ff;
         if (c_en) c_vld_ff <= b_vld_ff;
         if (d_en) d_vld_ff <= c_vld_ff;
         if (e_en) e_vld_ff <= d_vld_ff;
      end
   end

   // stage a: reciprocal multiplies and simple range checks
   logic [U_W-1:0]           u_in, u_ff;
   logic [34:0]              q_prod;
   logic [Q_W-1:0]           q_in, q_ff;
   logic [60:0]              n_prod;
   logic [MSN_W-1:0]         msn_in, msn_a_ff;
   logic signed [DAYS_W-1:0] dy_in, dy_ff;
   logic signed [U_W-1:0]    yrel;
   logic                     a_bad_in, a_bad_ff;
   logic [1:0]               ylow_ff;
   logic [MONTH_W-1:0]       month_ff;
   logic [DAY_W-1:0]         day_ff;
   logic [HOUR_W-1:0]        hour_ff;
   logic [MIN_W-1:0]         min_ff;
   logic [SEC_W-1:0]         sec_ff;

   always_comb begin
      u_in     = U_W'(req_if.year) + YEAR_OFS;
      q_prod   = 35'(u_in) * 35'(RECIP_100);
      q_in     = q_prod[33:24];
      n_prod   = 61'(req_if.nanosecond) * 61'(RECIP_1M);
      msn_in   = n_prod[59:50];
      yrel     = U_W'(req_if.year) - EPOCH_YEAR;
      dy_in    = DAYS_W'(yrel) * DAYS_W'(10'sd365);
      a_bad_in = (req_if.month < 4'd1) || (req_if.month > 4'd12) ||
                 (req_if.hour > 5'd23) || (req_if.minute > 6'd59) ||
                 (req_if.second > 6'd59) || (req_if.nanosecond > NANO_MAX);
   end

   always_ff @(posedge clock) begin
      if (a_en) begin
         u_ff     <= u_in;
         q_ff     <= q_in;
         msn_a_ff <= msn_in;
         dy_ff    <= dy_in;
         a_bad_ff <= a_bad_in;
         ylow_ff  <= req_if.year[1:0];
         month_ff <= req_if.month;
         day_ff   <= req_if.day_of_month;
         hour_ff  <= req_if.hour;
         min_ff   <= req_if.minute;
         sec_ff   <= req_if.second;
      end
   end

   // stage b: leap rule, day count and time of day
   logic [U_W-1:0]           rem100;
   logic                     leap;
   logic [DAY_W-1:0]         mlen;
   logic signed [DAYS_W-1:0] days_in, days_ff;
   logic [TOD_W-1:0]         tod_in, tod_ff;
   logic                     b_bad_in, b_bad_ff;
   logic [MSN_W-1:0]         msn_b_ff;

   always_comb begin
      rem100   = u_ff - U_W'({q_ff, 6'b0}) - U_W'({q_ff, 5'b0}) - U_W'({q_ff, 2'b0});
      // year divisible by 100 shows as remainder 99 of the shifted year - 1
      leap     = (ylow_ff == 2'd0) &&
                 ((rem100 != 17'd99) || (Q_W'(q_ff + 10'd1) & 10'd3) == 10'd0);
      mlen     = month_length(month_ff, leap);
      b_bad_in = a_bad_ff || (day_ff < 5'd1) || (day_ff > mlen);
      days_in  = dy_ff + DAYS_W'(u_ff[U_W-1:2]) - DAYS_W'(q_ff) + DAYS_W'(q_ff[Q_W-1:2])
                 - DAYS_W'(LEAP_BIAS) + DAYS_W'(days_before_month(month_ff))
                 + DAYS_W'(leap && (month_ff > 4'd2)) + DAYS_W'(day_ff) - 26'd1;
      tod_in   = TOD_W'(hour_ff) * 17'd3600 + TOD_W'(min_ff) * 17'd60 + TOD_W'(sec_ff);
   end

   always_ff @(posedge clock) begin
      if (b_en) begin
         days_ff  <= days_in;
         tod_ff   <= tod_in;
         b_bad_ff <= b_bad_in;
         msn_b_ff <= msn_a_ff;
      end
   end

   // stage c: days to seconds
   logic signed [SECS_W-1:0] sprod_in, sprod_ff;
   logic [TOD_W-1:0]         tod_c_ff;
   logic                     c_bad_ff;
   logic [MSN_W-1:0]         msn_c_ff;

   assign sprod_in = SECS_W'(days_ff) * SECS_W'(SEC_PER_DAY);

   always_ff @(posedge clock) begin
      if (c_en) begin
         sprod_ff <= sprod_in;
         tod_c_ff <= tod_ff;
         c_bad_ff <= b_bad_ff;
         msn_c_ff <= msn_b_ff;
      end
   end

   // stage d: add time of day
   logic signed [SECS_W-1:0] secs_in, secs_ff;
   logic                     d_bad_ff;
   logic [MSN_W-1:0]         msn_d_ff;

   assign secs_in = sprod_ff + SECS_W'(tod_c_ff);

   always_ff @(posedge clock) begin
      if (d_en) begin
         secs_ff  <= secs_in;
         d_bad_ff <= c_bad_ff;
         msn_d_ff <= msn_c_ff;
      end
   end

   // stage e: seconds to milliseconds, output register
   logic signed [MS_W-1:0] ms_full;
   logic signed [TS_W-1:0] ts_in, ts_ff;
   logic                   bad_ff;

   always_comb begin
      ms_full = MS_W'(secs_ff) * MS_W'(MS_PER_SEC) + $signed(MS_W'(msn_d_ff));
      ts_in   = d_bad_ff ? '0 : ms_full[TS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (e_en) begin
         ts_ff  <= ts_in;
         bad_ff <= d_bad_ff;
      end
   end

   assign rsp_if.valid        = e_vld_ff;
   assign rsp_if.timestamp_ms = ts_ff;
   assign rsp_if.invalid      = bad_ff;

   `ASSERT_NEXT(a_req_fills, clock, reset, req_fire, a_vld_ff)
   `ASSERT_NEXT(a_stall_holds, clock, reset, d_vld_ff && !e_en, d_vld_ff && e_vld_ff)
   `ASSERT_PROP(a_days_range, clock, reset,
                (c_vld_ff && !c_bad_ff) |-> ((sprod_ff >= -43'sd1123200000000) &&
                                             (sprod_ff <= 43'sd1123200000000)))
   `ASSERT_PROP(a_days_b_range, clock, reset,
                (b_vld_ff && !b_bad_ff) |-> ((days_ff >= -26'(DAYS_LIMIT)) &&
                                             (days_ff <= 26'(DAYS_LIMIT))))
   `ASSERT_PROP(a_bad_zero, clock, reset, (rsp_if.valid && rsp_if.invalid) |-> (rsp_if.timestamp_ms == '0))

endmodule
